@@ rtl/core/qrsd_pkg.sv @@
// Shared types and constants for the QRS peak and heart rate detector.
// Used by the controller, the datapath, the divider and the top level.
package qrsd_pkg;

    // Configuration register indexes
    localparam logic REG_SAMPLE_RATE = 1'b0;
    localparam logic REG_REFRACTORY  = 1'b1;

    // Reset values of the configuration registers
    localparam logic [11:0] SAMPLE_RATE_RESET = 12'd200;
    localparam logic [15:0] REFRACTORY_RESET  = 16'd40;

    // Filter and window geometry
    localparam int LP_TAPS    = 12;
    localparam int HP_TAPS    = 32;
    localparam int DV_TAPS    = 4;
    localparam int WIN_SHIFT  = 5;
    localparam int WIN_LEN    = 1 << WIN_SHIFT;
    localparam int RR_DEPTH   = 8;
    localparam int RR_CNT_W   = 4;
    localparam int RR_SUM_W   = 20;

    // Datapath widths
    localparam int X_W    = 24;
    localparam int ACC_W  = 40;
    localparam int LP_W   = 26;
    localparam int HP_W   = 28;
    localparam int D_W    = 24;
    localparam int SQ_W   = 40;
    localparam int LVL_W  = 48;

    // Division by 36: a shift by two, then a multiply by ceil(2^31 / 9).
    // The quarter magnitude stays below 2^27, where the product is exact.
    localparam int             LP_RECIP_W     = 28;
    localparam logic [27:0]    LP_RECIP       = 28'd238609295;

    // Heart rate divider widths
    localparam int DVD_W  = 27;
    localparam int DVS_W  = 21;

    localparam logic [12:0] HR_MAX = 13'd4800;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_in;
        logic lp_step;
        logic lp_mul;
        logic lp_capture;
        logic hp_step;
        logic dv_step;
        logic sq_step;
        logic win_step;
        logic det_step;
        logic thr_step;
        logic rr_step;
        logic num_step;
        logic hr_div_start;
        logic hr_capture;
        logic out_load;
    } qrsd_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_done;
        logic rr_needed;
        logic out_full;
    } qrsd_status_t;

endpackage

@@ rtl/core/qrsd_div.sv @@
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Depends on qrsd_pkg for its widths.
module qrsd_div
    import qrsd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output logic             done
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVS_W:0]   rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   shifted;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb
    begin
        shifted   = {rem_reg[DVS_W-1:0], dvd_reg[DVD_W-1]};
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = shifted - {1'b0, dvs_reg};
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Operand registers carry no control meaning.
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign quotient = dvd_reg;
    assign done     = done_reg;

endmodule

@@ rtl/core/qrsd_datapath.sv @@
// Datapath of the QRS detector: filters, integrator, peak logic, RR history.
// Depends on qrsd_pkg and instantiates the heart rate divider qrsd_div.
module qrsd_datapath
    import qrsd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  qrsd_cmd_t    cmd,
    output qrsd_status_t status,
    input  logic [15:0]  ecg_sample,
    input  logic         cfg_write,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         out_taken,
    output logic         out_valid,
    output logic         r_peak,
    output logic [12:0]  heart_rate_x16,
    output logic [15:0]  rr_interval_samples
);

    // Configuration
    logic [11:0] sample_rate_reg;
    logic [15:0] refractory_reg;

    // Filter state
    logic signed [X_W-1:0]   lp_line_reg [LP_TAPS];
    logic signed [ACC_W-1:0] lp_y1_reg, lp_y2_reg;
    logic signed [LP_W-1:0]  hp_line_reg [HP_TAPS];
    logic signed [ACC_W-1:0] hp_y1_reg;
    logic signed [HP_W-1:0]  dv_line_reg [DV_TAPS];
    logic [SQ_W-1:0]         win_line_reg [WIN_LEN];
    logic [LVL_W-1:0]        win_sum_reg;

    // Detection state
    logic [LVL_W-1:0]        sig_lvl_reg, noise_lvl_reg;
    logic signed [LVL_W:0]   thr_reg;
    logic [31:0]             count_reg, last_peak_reg;
    logic                    peak_seen_reg;
    logic [15:0]             rr_hist_reg [RR_DEPTH];
    logic [RR_SUM_W-1:0]     rr_sum_reg;
    logic [RR_CNT_W-1:0]     rr_cnt_reg;
    logic [15:0]             rr_last_reg;
    logic [12:0]             hr_reg;

    // Per-item working registers
    logic signed [X_W-1:0]   x_reg;
    logic signed [ACC_W-1:0] lp_n_reg;
    logic [54:0]             lp_prod_reg;
    logic signed [LP_W-1:0]  lp_reg;
    logic signed [HP_W-1:0]  hp_reg;
    logic signed [D_W-1:0]   d_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic [LVL_W-1:0]        mwi_reg;
    logic [31:0]             elapsed_reg;
    logic                    peak_reg;
    logic                    rr_needed_reg;
    logic [15:0]             rate_prod_reg;

    // Output register
    logic        out_valid_reg;
    logic        out_peak_reg;
    logic [12:0] out_hr_reg;
    logic [15:0] out_rr_reg;

    // Divider
    logic             div_start;
    logic [DVD_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    logic [DVD_W-1:0] div_quotient;
    logic             div_done;

    // Combinational stage values
    logic signed [ACC_W-1:0] lp_y;
    logic [ACC_W-1:0]        lp_mag;
    logic signed [LP_W-1:0]  lp_q;
    logic signed [ACC_W-1:0] hp_y;
    logic signed [ACC_W-1:0] hp_r;
    logic signed [31:0]      dv_s;
    logic signed [31:0]      dv_q;
    logic signed [2*D_W-1:0] d_sq;
    logic [LVL_W-1:0]        win_sum_next;
    logic [LVL_W-1:0]        mwi_calc;
    logic [31:0]             count_next;
    logic                    peak_now;
    logic [LVL_W+3:0]        lvl_mix;
    logic [LVL_W-1:0]        lvl_src;
    logic signed [LVL_W:0]   lvl_gap;
    logic [15:0]             rr_new;
    logic [RR_SUM_W-1:0]     rr_sum_next;
    logic [25:0]             hr_num;
    logic [26:0]             hr_dvd;
    logic [12:0]             hr_sat;

    // Low-pass recursion: y = 2*y1 - y2 + x - 2*x6 + x12
    assign lp_y = (lp_y1_reg <<< 1) - lp_y2_reg + ACC_W'(x_reg)
                - (ACC_W'(lp_line_reg[5]) <<< 1) + ACC_W'(lp_line_reg[11]);

    // Floor division by 36 runs on the magnitude; a negative numerator rounds down.
    assign lp_mag = lp_n_reg[ACC_W-1] ? $unsigned(ACC_W'(35) - lp_n_reg)
                                      : $unsigned(lp_n_reg);
    assign lp_q   = lp_n_reg[ACC_W-1] ? -LP_W'(lp_prod_reg[54:31])
                                      : LP_W'(lp_prod_reg[54:31]);

    // High-pass recursion kept at 32 times scale: y = y1 - x + 32*x16 - 32*x17 + x32
    assign hp_y = hp_y1_reg - ACC_W'(lp_reg) + (ACC_W'(hp_line_reg[15]) <<< 5)
                - (ACC_W'(hp_line_reg[16]) <<< 5) + ACC_W'(hp_line_reg[31]);
    assign hp_r = (hp_y + ACC_W'(16)) >>> 5;

    // Five-point derivative with rounding and saturation to 24 bits
    assign dv_s = (32'(hp_reg) <<< 1) + 32'(dv_line_reg[0]) - 32'(dv_line_reg[2])
                - (32'(dv_line_reg[3]) <<< 1) + 32'sd4;
    assign dv_q = dv_s >>> 3;

    assign d_sq = d_reg * d_reg;

    // Moving-window integrator
    assign win_sum_next = win_sum_reg - LVL_W'(win_line_reg[WIN_LEN-1]) + LVL_W'(sq_reg);
    assign mwi_calc     = (win_sum_next + LVL_W'(WIN_LEN / 2)) >> WIN_SHIFT;

    // Peak decision and the level that moves toward the integrated value
    assign count_next = count_reg + 32'd1;
    assign peak_now   = ($signed({1'b0, mwi_reg}) > thr_reg)
                      && (elapsed_reg > {16'd0, refractory_reg});
    assign lvl_src    = peak_now ? sig_lvl_reg : noise_lvl_reg;
    assign lvl_mix    = ({4'd0, mwi_reg} + ({4'd0, lvl_src} << 3) - {4'd0, lvl_src}
                      + (LVL_W+4)'(4)) >> 3;
    assign lvl_gap    = ($signed({1'b0, sig_lvl_reg}) - $signed({1'b0, noise_lvl_reg})
                      + (LVL_W+1)'(2)) >>> 2;

    // Interval history
    assign rr_new      = (elapsed_reg > 32'd65535) ? 16'hFFFF : elapsed_reg[15:0];
    assign rr_sum_next = rr_sum_reg - RR_SUM_W'(rr_hist_reg[RR_DEPTH-1]) + RR_SUM_W'(rr_new);

    // Heart rate: round(960 * rate * count / sum) as (2*num + sum) / (2*sum)
    assign hr_num = ({rate_prod_reg, 10'd0}) - (26'(rate_prod_reg) << 6);
    assign hr_dvd = {hr_num, 1'b0} + 27'(rr_sum_reg);
    assign hr_sat = (div_quotient > DVD_W'(HR_MAX)) ? HR_MAX : div_quotient[12:0];

    // Divider operands
    assign div_start    = cmd.hr_div_start;
    assign div_dividend = hr_dvd;
    assign div_divisor  = {rr_sum_reg, 1'b0};

    qrsd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    // Configuration, filter and detection state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_rate_reg <= SAMPLE_RATE_RESET;
            refractory_reg  <= REFRACTORY_RESET;
            for (int i = 0; i < LP_TAPS; i++)
            begin
                lp_line_reg[i] <= '0;
            end
            for (int i = 0; i < HP_TAPS; i++)
            begin
                hp_line_reg[i] <= '0;
            end
            for (int i = 0; i < DV_TAPS; i++)
            begin
                dv_line_reg[i] <= '0;
            end
            for (int i = 0; i < WIN_LEN; i++)
            begin
                win_line_reg[i] <= '0;
            end
            for (int i = 0; i < RR_DEPTH; i++)
            begin
                rr_hist_reg[i] <= '0;
            end
            lp_y1_reg     <= '0;
            lp_y2_reg     <= '0;
            hp_y1_reg     <= '0;
            win_sum_reg   <= '0;
            sig_lvl_reg   <= '0;
            noise_lvl_reg <= '0;
            thr_reg       <= '0;
            count_reg     <= '0;
            last_peak_reg <= '0;
            peak_seen_reg <= 1'b0;
            rr_sum_reg    <= '0;
            rr_cnt_reg    <= '0;
            rr_last_reg   <= '0;
            hr_reg        <= '0;
            rr_needed_reg <= 1'b0;
            peak_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_SAMPLE_RATE: sample_rate_reg <= cfg_data[11:0];
                    REG_REFRACTORY:  refractory_reg  <= cfg_data;
                    default: ;
                endcase
            end

            // Low-pass state moves once the new input is registered.
            if (cmd.lp_step)
            begin
                lp_y1_reg <= lp_y;
                lp_y2_reg <= lp_y1_reg;
                lp_line_reg[0] <= x_reg;
                for (int i = 1; i < LP_TAPS; i++)
                begin
                    lp_line_reg[i] <= lp_line_reg[i-1];
                end
            end

            if (cmd.hp_step)
            begin
                hp_y1_reg      <= hp_y;
                hp_line_reg[0] <= lp_reg;
                for (int i = 1; i < HP_TAPS; i++)
                begin
                    hp_line_reg[i] <= hp_line_reg[i-1];
                end
            end

            if (cmd.dv_step)
            begin
                dv_line_reg[0] <= hp_reg;
                for (int i = 1; i < DV_TAPS; i++)
                begin
                    dv_line_reg[i] <= dv_line_reg[i-1];
                end
            end

            if (cmd.win_step)
            begin
                win_sum_reg     <= win_sum_next;
                win_line_reg[0] <= sq_reg;
                for (int i = 1; i < WIN_LEN; i++)
                begin
                    win_line_reg[i] <= win_line_reg[i-1];
                end
            end

            // Peak decision updates one of the two levels.
            if (cmd.det_step)
            begin
                peak_reg      <= peak_now;
                rr_needed_reg <= peak_now && peak_seen_reg;
                if (peak_now)
                begin
                    peak_seen_reg <= 1'b1;
                    last_peak_reg <= count_reg;
                    sig_lvl_reg   <= lvl_mix[LVL_W-1:0];
                end
                else
                begin
                    noise_lvl_reg <= lvl_mix[LVL_W-1:0];
                end
            end

            if (cmd.thr_step)
            begin
                thr_reg <= $signed({1'b0, noise_lvl_reg}) + lvl_gap;
            end

            if (cmd.rr_step)
            begin
                rr_hist_reg[0] <= rr_new;
                for (int i = 1; i < RR_DEPTH; i++)
                begin
                    rr_hist_reg[i] <= rr_hist_reg[i-1];
                end
                rr_sum_reg  <= rr_sum_next;
                rr_last_reg <= rr_new;
                if (rr_cnt_reg < RR_CNT_W'(RR_DEPTH))
                begin
                    rr_cnt_reg <= rr_cnt_reg + 1'b1;
                end
            end

            // A zero interval sum leaves the rate as it was.
            if (cmd.hr_capture && (rr_sum_reg != '0))
            begin
                hr_reg <= hr_sat;
            end

            if (cmd.win_step)
            begin
                count_reg <= count_next;
            end

            // Output word register
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_taken)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Per-item working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            x_reg <= $signed({ecg_sample, 8'd0});
        end
        if (cmd.lp_step)
        begin
            lp_n_reg <= lp_y + ACC_W'(18);
        end
        if (cmd.lp_mul)
        begin
            lp_prod_reg <= lp_mag[28:2] * LP_RECIP;
        end
        if (cmd.lp_capture)
        begin
            lp_reg <= lp_q;
        end
        if (cmd.hp_step)
        begin
            hp_reg <= hp_r[HP_W-1:0];
        end
        if (cmd.dv_step)
        begin
            if (dv_q > 32'sd8388607)
            begin
                d_reg <= 24'sh7FFFFF;
            end
            else if (dv_q < -32'sd8388608)
            begin
                d_reg <= -24'sh800000;
            end
            else
            begin
                d_reg <= dv_q[D_W-1:0];
            end
        end
        if (cmd.sq_step)
        begin
            sq_reg <= SQ_W'(($unsigned(d_sq) + 48'd128) >> 8);
        end
        if (cmd.win_step)
        begin
            mwi_reg     <= mwi_calc;
            elapsed_reg <= count_next - last_peak_reg;
        end
        if (cmd.num_step)
        begin
            rate_prod_reg <= 16'(sample_rate_reg) * 16'(rr_cnt_reg);
        end
        if (cmd.out_load)
        begin
            out_peak_reg <= peak_reg;
            out_hr_reg   <= hr_reg;
            out_rr_reg   <= rr_last_reg;
        end
    end

    assign status.div_done  = div_done;
    assign status.rr_needed = rr_needed_reg;
    assign status.out_full  = out_valid_reg;

    assign out_valid           = out_valid_reg;
    assign r_peak              = out_peak_reg;
    assign heart_rate_x16      = out_hr_reg;
    assign rr_interval_samples = out_rr_reg;

endmodule

@@ rtl/core/qrsd_ctrl.sv @@
// Controller of the QRS detector: steps one sample through the datapath.
// Depends on qrsd_pkg for the command and status types.
module qrsd_ctrl
    import qrsd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_fire,
    input  qrsd_status_t status,
    output qrsd_cmd_t    cmd,
    output logic         idle
);

    typedef enum logic [14:0] {
        ST_IDLE    = 15'b000000000000001,
        ST_LP      = 15'b000000000000010,
        ST_LP_MUL  = 15'b000000000000100,
        ST_LP_OUT  = 15'b000000000001000,
        ST_HP      = 15'b000000000010000,
        ST_DV      = 15'b000000000100000,
        ST_SQ      = 15'b000000001000000,
        ST_WIN     = 15'b000000010000000,
        ST_DET     = 15'b000000100000000,
        ST_THR     = 15'b000001000000000,
        ST_RR      = 15'b000010000000000,
        ST_NUM     = 15'b000100000000000,
        ST_HR_DIV  = 15'b001000000000000,
        ST_HR_WAIT = 15'b010000000000000,
        ST_OUT     = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (in_fire) state_next = ST_LP;
            ST_LP:      state_next = ST_LP_MUL;
            ST_LP_MUL:  state_next = ST_LP_OUT;
            ST_LP_OUT:  state_next = ST_HP;
            ST_HP:      state_next = ST_DV;
            ST_DV:      state_next = ST_SQ;
            ST_SQ:      state_next = ST_WIN;
            ST_WIN:     state_next = ST_DET;
            ST_DET:     state_next = ST_THR;
            ST_THR:     state_next = status.rr_needed ? ST_RR : ST_OUT;
            ST_RR:      state_next = ST_NUM;
            ST_NUM:     state_next = ST_HR_DIV;
            ST_HR_DIV:  state_next = ST_HR_WAIT;
            ST_HR_WAIT: if (status.div_done) state_next = ST_OUT;
            ST_OUT:     if (!status.out_full) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Commands decoded from the state
    always_comb
    begin
        cmd              = '0;
        cmd.load_in      = (state_reg == ST_IDLE) && in_fire;
        cmd.lp_step      = (state_reg == ST_LP);
        cmd.lp_mul       = (state_reg == ST_LP_MUL);
        cmd.lp_capture   = (state_reg == ST_LP_OUT);
        cmd.hp_step      = (state_reg == ST_HP);
        cmd.dv_step      = (state_reg == ST_DV);
        cmd.sq_step      = (state_reg == ST_SQ);
        cmd.win_step     = (state_reg == ST_WIN);
        cmd.det_step     = (state_reg == ST_DET);
        cmd.thr_step     = (state_reg == ST_THR);
        cmd.rr_step      = (state_reg == ST_RR);
        cmd.num_step     = (state_reg == ST_NUM);
        cmd.hr_div_start = (state_reg == ST_HR_DIV);
        cmd.hr_capture   = (state_reg == ST_HR_WAIT) && status.div_done;
        cmd.out_load     = (state_reg == ST_OUT) && !status.out_full;
    end

    assign idle = (state_reg == ST_IDLE);

endmodule

@@ rtl/core/qrs_peak_heart_rate_detector_top.sv @@
// Top level of the QRS peak and heart rate detector.
// Depends on qrsd_pkg, qrsd_ctrl and qrsd_datapath.
//
// One signed ECG sample enters per input word and gives exactly one result
// word: the R peak flag, the averaged heart rate in 1/16 bpm and the latest
// RR interval. The block works on one sample at a time. A sample without a
// peak, or the first peak, passes through ST_LP to ST_THR and ST_OUT before
// the next sample is accepted; the low-pass gain of 36 is divided out by a
// shift and a reciprocal multiply in ST_LP, ST_LP_MUL and ST_LP_OUT. A peak
// that closes an RR interval also goes through ST_RR, ST_NUM, ST_HR_DIV and
// ST_HR_WAIT, which waits on the bit-serial divider that turns the
// averaged interval into bpm. A finished result waits in an output register,
// and the next sample is taken while it waits; that sample then holds in its
// last step until the earlier word has left. Configuration writes are taken
// in any cycle and should be made while no sample is in progress.
module qrs_peak_heart_rate_detector_top
    import qrsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input samples
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] ecg_sample
    // Results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [0] r_peak, [13:1] heart_rate_x16,
                                        // [29:14] rr_interval_samples, [31:30] zero
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    qrsd_cmd_t    cmd;
    qrsd_status_t status;
    logic         idle;
    logic         in_fire;
    logic         r_peak;
    logic [12:0]  heart_rate_x16;
    logic [15:0]  rr_interval_samples;

    assign s_axis_tready = idle;
    assign in_fire       = s_axis_tvalid && idle;
    assign cfg_ready     = 1'b1;

    qrsd_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .status  (status),
        .cmd     (cmd),
        .idle    (idle)
    );

    qrsd_datapath u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .ecg_sample          (s_axis_tdata),
        .cfg_write           (cfg_valid),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .out_taken           (m_axis_tready),
        .out_valid           (m_axis_tvalid),
        .r_peak              (r_peak),
        .heart_rate_x16      (heart_rate_x16),
        .rr_interval_samples (rr_interval_samples)
    );

    assign m_axis_tdata = {2'b00, rr_interval_samples, heart_rate_x16, r_peak};

endmodule

@@ test/qrs_peak_heart_rate_detector_top_test.sv @@
// Self-checking testbench for the QRS peak and heart rate detector top level.
// Depends on qrsd_pkg and qrs_peak_heart_rate_detector_top; models the filter
// chain, peak logic and rate averaging internally and checks every result word.
module qrs_peak_heart_rate_detector_top_test
    import qrsd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LP_LEN        = 13;
    localparam int HP_LEN        = 33;
    localparam int DV_LEN        = 5;
    localparam int WINDOW        = 32;
    localparam int RR_SLOTS      = 8;
    localparam int SETTLE_CYCLES = 150;
    localparam int STALL_LIMIT   = 4000;
    localparam int IDLE_PCT      = 38;

    typedef enum logic [1:0] {WORD_SAMPLE, WORD_CFG, WORD_DRAIN} word_kind_t;

    typedef struct {
        word_kind_t  kind;
        logic [15:0] data;
        logic        index;
    } pending_word_t;

    typedef struct {
        logic        peak;
        logic [12:0] rate_x16;
        logic [15:0] interval;
    } beat_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;     // [15:0] ecg_sample
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;     // [0] r_peak, [13:1] heart_rate_x16,
                                   // [29:14] rr_interval_samples
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    pending_word_t pending_q[$];
    beat_result_t  beat_q[$];
    int            errors;
    int            samples_sent;
    int            results_seen;
    int            peaks_seen;
    int            cfg_writes;
    int            settle;
    int            stall_count;

    // Detector state kept by the testbench
    logic [11:0]  rate_hz;
    logic [15:0]  refractory;
    longint       lp_line [LP_LEN];
    longint       lp_y0, lp_y1;
    longint       hp_line [HP_LEN];
    longint       hp_y;
    longint       dv_line [DV_LEN];
    longint       win_sq [WINDOW];
    longint       win_sum;
    longint       sig_level, noise_level, threshold;
    logic [31:0]  sample_count, last_peak;
    logic [15:0]  rr_hist [RR_SLOTS];
    int           rr_wp, rr_cnt;
    logic [12:0]  rate_reg;
    int           lp_pos, hp_pos, dv_pos, win_pos;
    bit           had_peak;

    qrs_peak_heart_rate_detector_top u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Floor division by a positive divisor.
    function automatic longint floor_div(input longint n, input longint d);
        if (n >= 0)
            return n / d;
        return -(((-n) + d - 1) / d);
    endfunction

    task automatic reset_model();
        rate_hz = SAMPLE_RATE_RESET;
        refractory = REFRACTORY_RESET;
        foreach (lp_line[i]) lp_line[i] = 0;
        foreach (hp_line[i]) hp_line[i] = 0;
        foreach (dv_line[i]) dv_line[i] = 0;
        foreach (win_sq[i]) win_sq[i] = 0;
        foreach (rr_hist[i]) rr_hist[i] = '0;
        lp_y0 = 0; lp_y1 = 0; hp_y = 0; win_sum = 0;
        sig_level = 0; noise_level = 0; threshold = 0;
        sample_count = '0; last_peak = '0;
        rr_wp = 0; rr_cnt = 0; rate_reg = '0;
        lp_pos = 0; hp_pos = 0; dv_pos = 0; win_pos = 0;
        had_peak = 0;
    endtask

    // Store a new RR interval and refresh the averaged heart rate.
    task automatic record_rr(input logic [31:0] span);
        longint sum, num, hr;
        sum = 0;
        rr_hist[rr_wp] = (span > 32'd65535) ? 16'hFFFF : span[15:0];
        rr_wp = (rr_wp + 1) % RR_SLOTS;
        if (rr_cnt < RR_SLOTS)
            rr_cnt++;
        for (int i = 0; i < rr_cnt; i++)
            sum += rr_hist[i];
        if (sum != 0)
        begin
            num = 960 * longint'(rate_hz) * rr_cnt;
            hr = (2 * num + sum) / (2 * sum);
            rate_reg = (hr > HR_MAX) ? HR_MAX : hr[12:0];
        end
    endtask

    // Run one sample through the filter chain and queue its result word.
    task automatic predict_beat(input logic [15:0] raw);
        longint       x, x6, x12, y, lp, hp, x16, x17, x32, x1, x3, x4, d, sq, mwi;
        logic [31:0]  span;
        beat_result_t r;
        x = longint'($signed(raw)) * 256;
        lp_line[lp_pos] = x;
        x6 = lp_line[(lp_pos + LP_LEN - 6) % LP_LEN];
        x12 = lp_line[(lp_pos + LP_LEN - 12) % LP_LEN];
        y = 2 * lp_y0 - lp_y1 + x - 2 * x6 + x12;
        lp_y1 = lp_y0;
        lp_y0 = y;
        lp_pos = (lp_pos + 1) % LP_LEN;
        lp = floor_div(y + 18, 36);

        hp_line[hp_pos] = lp;
        x16 = hp_line[(hp_pos + HP_LEN - 16) % HP_LEN];
        x17 = hp_line[(hp_pos + HP_LEN - 17) % HP_LEN];
        x32 = hp_line[(hp_pos + HP_LEN - 32) % HP_LEN];
        hp_y = hp_y - lp + 32 * x16 - 32 * x17 + x32;
        hp_pos = (hp_pos + 1) % HP_LEN;
        hp = floor_div(hp_y + 16, 32);

        dv_line[dv_pos] = hp;
        x1 = dv_line[(dv_pos + DV_LEN - 1) % DV_LEN];
        x3 = dv_line[(dv_pos + DV_LEN - 3) % DV_LEN];
        x4 = dv_line[(dv_pos + DV_LEN - 4) % DV_LEN];
        dv_pos = (dv_pos + 1) % DV_LEN;
        d = floor_div(2 * hp + x1 - x3 - 2 * x4 + 4, 8);
        if (d > 8388607) d = 8388607;
        if (d < -8388608) d = -8388608;

        sq = (d * d + 128) >>> 8;
        win_sum = win_sum - win_sq[win_pos] + sq;
        win_sq[win_pos] = sq;
        win_pos = (win_pos + 1) % WINDOW;
        mwi = (win_sum + WINDOW / 2) / WINDOW;

        // Peak decision with the refractory gap, then level tracking.
        sample_count = sample_count + 1;
        span = sample_count - last_peak;
        r.peak = (mwi > threshold) && (span > {16'd0, refractory});
        if (r.peak)
        begin
            if (had_peak)
                record_rr(span);
            had_peak = 1;
            last_peak = sample_count;
            sig_level = (mwi + 7 * sig_level + 4) >>> 3;
        end
        else
            noise_level = (mwi + 7 * noise_level + 4) >>> 3;
        threshold = noise_level + floor_div(sig_level - noise_level + 2, 4);

        r.rate_x16 = rate_reg;
        r.interval = (rr_cnt > 0) ? rr_hist[(rr_wp + RR_SLOTS - 1) % RR_SLOTS] : 16'd0;
        beat_q.push_back(r);
    endtask

    function automatic bit calm_stretch();
        return samples_sent >= 400 && samples_sent < 560;
    endfunction

    // Input driver: presents queued samples and register writes.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            cfg_valid <= 1'b0;
            cfg_index <= REG_SAMPLE_RATE;
            cfg_data <= '0;
            settle = 0;
        end
        else
        begin
            logic next_s, next_c;
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_beat(s_axis_tdata);
                samples_sent++;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_SAMPLE_RATE)
                    rate_hz = cfg_data[11:0];
                else
                    refractory = cfg_data;
                cfg_writes++;
            end
            settle = (beat_q.size() == 0) ? settle + 1 : 0;

            if (!(s_axis_tvalid && !s_axis_tready) && !(cfg_valid && !cfg_ready))
            begin
                next_s = 1'b0;
                next_c = 1'b0;
                if (pending_q.size() > 0)
                begin
                    case (pending_q[0].kind)
                        WORD_SAMPLE:
                            if (calm_stretch() || $urandom_range(99) >= IDLE_PCT)
                            begin
                                next_s = 1'b1;
                                s_axis_tdata <= pending_q[0].data;
                                void'(pending_q.pop_front());
                            end
                        WORD_CFG:
                            if (settle >= SETTLE_CYCLES)
                            begin
                                next_c = 1'b1;
                                cfg_index <= pending_q[0].index;
                                cfg_data <= pending_q[0].data;
                                void'(pending_q.pop_front());
                            end
                        default:
                            if (beat_q.size() == 0)
                                void'(pending_q.pop_front());
                    endcase
                end
                s_axis_tvalid <= next_s;
                cfg_valid <= next_c;
            end
        end
    end

    // Result monitor: compares each result word with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                beat_result_t e;
                results_seen++;
                if (beat_q.size() == 0)
                begin
                    $display("%0t: unexpected result word %h", $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    e = beat_q.pop_front();
                    if (e.peak) peaks_seen++;
                    if (m_axis_tdata[0] !== e.peak)
                    begin
                        $display("%0t: r_peak expected %0d actual %0d",
                                 $time, e.peak, m_axis_tdata[0]);
                        errors++;
                    end
                    if (m_axis_tdata[13:1] !== e.rate_x16)
                    begin
                        $display("%0t: heart_rate_x16 expected %0d actual %0d",
                                 $time, e.rate_x16, m_axis_tdata[13:1]);
                        errors++;
                    end
                    if (m_axis_tdata[29:14] !== e.interval)
                    begin
                        $display("%0t: rr_interval expected %0d actual %0d",
                                 $time, e.interval, m_axis_tdata[29:14]);
                        errors++;
                    end
                end
            end
            m_axis_tready <= calm_stretch() || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            stall_count <= 0;
        else if (stall_count >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
        else
            stall_count <= stall_count + 1;
    end

    task automatic add_sample(input int v);
        pending_q.push_back('{WORD_SAMPLE, v[15:0], 1'b0});
    endtask

    task automatic add_config(input logic idx, input logic [15:0] v);
        pending_q.push_back('{WORD_CFG, v, idx});
    endtask

    // Pulse train with random period, amplitude and baseline noise.
    task automatic add_ecg_run(input int count);
        int period, amp, n;
        period = $urandom_range(6, 60);
        n = 0;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 20)
                add_sample($urandom);
            else if (n % period == 0)
            begin
                amp = $urandom_range(1000, 32767);
                add_sample($urandom_range(1) ? amp : -amp - 1);
            end
            else
                add_sample(int'($urandom_range(400)) - 200);
            n++;
            if ($urandom_range(99) < 3)
            begin
                period = $urandom_range(6, 60);
                n = 0;
            end
        end
    endtask

    initial
    begin
        static logic [15:0] rates [5] = '{16'd4000, 16'd0, 16'd1, 16'hFFFF, 16'd250};
        static logic [15:0] gaps  [5] = '{16'd0, 16'd5, 16'hFFFF, 16'd12, 16'd40};
        errors = 0; samples_sent = 0; results_seen = 0; peaks_seen = 0; cfg_writes = 0;
        reset_model();
        rst_n = 1'b0;

        // Directed part: field extremes, derivative overflow steps, a few beats.
        add_sample(0);
        add_sample(32767);
        add_sample(-32768);
        add_sample(32767);
        add_sample(-32768);
        add_sample(-1);
        add_sample(1);
        add_sample(16'h5555);
        add_sample(16'hAAAA);
        for (int i = 0; i < 14; i++)
            add_sample((i % 7 == 0) ? 30000 : 0);

        // Random phases over several register settings, extremes included.
        for (int p = 0; p < 5; p++)
        begin
            pending_q.push_back('{WORD_DRAIN, 16'd0, 1'b0});
            add_config(REG_SAMPLE_RATE, rates[p]);
            add_config(REG_REFRACTORY, gaps[p]);
            add_ecg_run(95);
            pending_q.push_back('{WORD_DRAIN, 16'd0, 1'b0});
            add_ecg_run(95);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_q.size() == 0 && beat_q.size() == 0 && !s_axis_tvalid);
        repeat (200) @(posedge clk);
        if (beat_q.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, beat_q.size());
            errors++;
        end
        $display("Run covered %0d samples, %0d result words with %0d R peaks,",
                 samples_sent, results_seen, peaks_seen);
        $display("and %0d register writes across six rate and refractory settings.",
                 cfg_writes);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/qrsd_pkg.sv
rtl/core/qrsd_div.sv
rtl/core/qrsd_datapath.sv
rtl/core/qrsd_ctrl.sv
rtl/core/qrs_peak_heart_rate_detector_top.sv
test/qrs_peak_heart_rate_detector_top_test.sv
